@@ hdl/mexp_pkg.sv @@
// modexp package: sizes, state codes and the cell control struct
`timescale 1ns / 1ps
package mexp_pkg;

  localparam int OPERAND_BITS = 512;
  localparam int WORD_BITS    = 64;
  localparam int NWORDS       = (OPERAND_BITS + WORD_BITS - 1) / WORD_BITS;
  // one spare cell on top holds the overflow of 2r + b before the subtracts
  localparam int NCELLS       = NWORDS + 1;
  localparam int RBITS        = NCELLS * WORD_BITS;
  localparam int PADBITS      = NWORDS * WORD_BITS;
  localparam int MAX_OUT      = 8;
  localparam int OUT_WORDS    = (NWORDS < MAX_OUT) ? NWORDS : MAX_OUT;
  localparam int IDX_W        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W        = $clog2(OPERAND_BITS + 1);
  localparam int IN_DATA_W    = 72;
  localparam int OUT_DATA_W   = 72;

  typedef enum logic [1:0] {
    ACT_LOAD_BASE = 2'd0,
    ACT_LOAD_EXP  = 2'd1,
    ACT_LOAD_MOD  = 2'd2,
    ACT_START     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MK_BASE = 2'd0,
    MK_ACC  = 2'd1,
    MK_SQR  = 2'd2
  } mul_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_CHECK   = 3'd1,
    ST_MUL_ADD = 3'd2,
    ST_MUL_SUB1 = 3'd3,
    ST_MUL_SUB2 = 3'd4,
    ST_MUL_DONE = 3'd5,
    ST_EXP_STEP = 3'd6,
    ST_OUT     = 3'd7
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift_add;
    logic add_bit;
    logic sub_take;
  } cell_ctl_t;

endpackage

@@ hdl/mexp_cell.sv @@
// modexp cell: one word slice of the remainder with shift, add and subtract
`timescale 1ns / 1ps
module mexp_cell (
  input  logic                                clk,
  input  mexp_pkg::cell_ctl_t                 ctl,
  input  logic [mexp_pkg::WORD_BITS-1:0]      mcand,
  input  logic [mexp_pkg::WORD_BITS-1:0]      modv,
  input  logic                                shift_in,
  input  logic                                carry_in,
  input  logic                                borrow_in,
  output logic                                shift_out,
  output logic                                carry_out,
  output logic                                borrow_out,
  output logic [mexp_pkg::WORD_BITS-1:0]      r_q
);

  localparam int W = mexp_pkg::WORD_BITS;

  logic [W-1:0] r_r;
  logic [W-1:0] shl;
  logic [W-1:0] addend;
  logic [W:0]   sum;
  logic [W:0]   diff;

  // doubled slice plus multiplicand, carry rippling up the row
  always_comb begin
    shl    = {r_r[W-2:0], shift_in};
    addend = ctl.add_bit ? mcand : '0;
    sum    = {1'b0, shl} + {1'b0, addend} + (W+1)'(carry_in);
    diff   = {1'b0, r_r} - {1'b0, modv} - (W+1)'(borrow_in);
  end

  assign shift_out  = r_r[W-1];
  assign carry_out  = sum[W];
  assign borrow_out = diff[W];
  assign r_q        = r_r;

  // slice update
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      r_r <= '0;
    end else if (ctl.shift_add) begin
      r_r <= sum[W-1:0];
    end else if (ctl.sub_take) begin
      r_r <= diff[W-1:0];
    end
  end

endmodule

@@ hdl/modular_exponentiation_core.sv @@
// modexp top level: operand stores, square-and-multiply sequencer, cell row
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tuser=action, tdata=word_index,word_value
// out_     out  out_tvalid/out_tready tdata=result_word,result_index,
//                                     tuser=error, tlast=last
//
// a start runs up to about 2*OPERAND_BITS modular multiplies, each a double-and-add
// then two conditional subtracts per multiplier bit in the cell row, plus one
// exponent step per exponent bit. results follow as OUT_WORDS beats, one per cycle
// when out_tready is high.
// rst_n is synchronous; operands reset to zero. in_tready is low while busy.
`timescale 1ns / 1ps
module modular_exponentiation_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mexp_pkg::IN_DATA_W-1:0]       in_tdata,  // word_index[2:0], word_value[66:3]
  input  logic [1:0]                           in_tuser,  // action[1:0]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mexp_pkg::OUT_DATA_W-1:0]      out_tdata, // result_word[63:0], result_index[66:64]
  output logic                                 out_tuser, // error[0]
  output logic                                 out_tlast
);

  localparam int OB = mexp_pkg::OPERAND_BITS;
  localparam int WB = mexp_pkg::WORD_BITS;
  localparam int NW = mexp_pkg::NWORDS;
  localparam int NC = mexp_pkg::NCELLS;

  mexp_pkg::state_t    state_r, state_nxt;
  mexp_pkg::mul_kind_t kind_r, kind_nxt;
  mexp_pkg::cell_ctl_t ctl;

  logic [WB-1:0] base_r [NW];
  logic [WB-1:0] exp_r  [NW];
  logic [WB-1:0] mod_r  [NW];

  logic [OB-1:0] acc_r, b_r, e_r, a_r;
  logic [mexp_pkg::CNT_W-1:0] cnt_r;
  logic [2:0]    out_idx_r;
  logic          err_r;

  logic [mexp_pkg::PADBITS-1:0] base_pad, exp_pad, mod_pad, acc_pad;
  logic [OB-1:0] base_flat, exp_flat, mod_flat, mult_sel;
  logic [mexp_pkg::RBITS-1:0] mcand_pad, m_rpad, r_flat;
  logic          mod_zero, exp_zero, e_more, start_mul;
  logic          in_beat, out_beat;
  logic [2:0]    in_idx;
  logic [WB-1:0] in_word;
  logic [NC:0]   shift_c, carry_c, borrow_c;
  logic [WB-1:0] acc_word;

  assign in_idx  = in_tdata[2:0];
  assign in_word = in_tdata[3 +: WB];
  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // flatten operand words, bits above the operand width dropped
  always_comb begin
    for (int k = 0; k < NW; k++) begin
      base_pad[k*WB +: WB] = base_r[k];
      exp_pad[k*WB +: WB]  = exp_r[k];
      mod_pad[k*WB +: WB]  = mod_r[k];
    end
    base_flat = base_pad[OB-1:0];
    exp_flat  = exp_pad[OB-1:0];
    mod_flat  = mod_pad[OB-1:0];
    acc_pad   = mexp_pkg::PADBITS'(acc_r);
  end

  assign mod_zero = (mod_flat == '0);
  assign exp_zero = (exp_flat == '0);
  assign e_more   = (e_r[OB-1:1] != '0);

  // multiplicand and modulus widened to the row
  always_comb begin
    if (kind_r == mexp_pkg::MK_BASE) begin
      mcand_pad = mexp_pkg::RBITS'(1);
    end else begin
      mcand_pad = mexp_pkg::RBITS'(b_r);
    end
    m_rpad = mexp_pkg::RBITS'(mod_flat);
  end

  // next state and multiply launches
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    start_mul = 1'b0;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_beat && (in_tuser == mexp_pkg::ACT_START)) begin
          state_nxt = mexp_pkg::ST_CHECK;
        end
      end
      mexp_pkg::ST_CHECK: begin
        if (mod_zero || exp_zero) begin
          state_nxt = mexp_pkg::ST_OUT;
        end else begin
          state_nxt = mexp_pkg::ST_MUL_ADD;
          kind_nxt  = mexp_pkg::MK_BASE;
          start_mul = 1'b1;
        end
      end
      mexp_pkg::ST_MUL_ADD:  state_nxt = mexp_pkg::ST_MUL_SUB1;
      mexp_pkg::ST_MUL_SUB1: state_nxt = mexp_pkg::ST_MUL_SUB2;
      mexp_pkg::ST_MUL_SUB2: begin
        state_nxt = (cnt_r == '0) ? mexp_pkg::ST_MUL_DONE : mexp_pkg::ST_MUL_ADD;
      end
      mexp_pkg::ST_MUL_DONE: begin
        case (kind_r)
          mexp_pkg::MK_ACC: begin
            if (e_more) begin
              state_nxt = mexp_pkg::ST_MUL_ADD;
              kind_nxt  = mexp_pkg::MK_SQR;
              start_mul = 1'b1;
            end else begin
              state_nxt = mexp_pkg::ST_OUT;
            end
          end
          default: state_nxt = mexp_pkg::ST_EXP_STEP;
        endcase
      end
      mexp_pkg::ST_EXP_STEP: begin
        if (e_r[0]) begin
          state_nxt = mexp_pkg::ST_MUL_ADD;
          kind_nxt  = mexp_pkg::MK_ACC;
          start_mul = 1'b1;
        end else if (e_more) begin
          state_nxt = mexp_pkg::ST_MUL_ADD;
          kind_nxt  = mexp_pkg::MK_SQR;
          start_mul = 1'b1;
        end else begin
          state_nxt = mexp_pkg::ST_OUT;
        end
      end
      mexp_pkg::ST_OUT: begin
        if (out_beat && (out_idx_r == 3'(mexp_pkg::OUT_WORDS - 1))) begin
          state_nxt = mexp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  // handshakes and cell row control
  always_comb begin
    in_tready     = 1'b0;
    out_tvalid    = 1'b0;
    ctl.clear     = start_mul;
    ctl.shift_add = 1'b0;
    ctl.add_bit   = 1'b0;
    ctl.sub_take  = 1'b0;
    case (state_r)
      mexp_pkg::ST_IDLE: in_tready = 1'b1;
      mexp_pkg::ST_MUL_ADD: begin
        ctl.shift_add = 1'b1;
        ctl.add_bit   = a_r[OB-1];
      end
      mexp_pkg::ST_MUL_SUB1,
      mexp_pkg::ST_MUL_SUB2: ctl.sub_take = !borrow_c[NC];
      mexp_pkg::ST_OUT: out_tvalid = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // multiplier source for a launch
  always_comb begin
    case (kind_nxt)
      mexp_pkg::MK_BASE: mult_sel = base_flat;
      mexp_pkg::MK_ACC:  mult_sel = acc_r;
      default:           mult_sel = b_r;
    endcase
  end

  // row of remainder cells
  assign shift_c[0]  = 1'b0;
  assign carry_c[0]  = 1'b0;
  assign borrow_c[0] = 1'b0;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    mexp_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .mcand      (mcand_pad[g*WB +: WB]),
      .modv       (m_rpad[g*WB +: WB]),
      .shift_in   (shift_c[g]),
      .carry_in   (carry_c[g]),
      .borrow_in  (borrow_c[g]),
      .shift_out  (shift_c[g+1]),
      .carry_out  (carry_c[g+1]),
      .borrow_out (borrow_c[g+1]),
      .r_q        (r_flat[g*WB +: WB])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mexp_pkg::ST_IDLE;
      kind_r    <= mexp_pkg::MK_BASE;
      out_idx_r <= '0;
      err_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      if (state_r == mexp_pkg::ST_CHECK) begin
        err_r     <= mod_zero;
        out_idx_r <= '0;
      end else if (out_beat) begin
        out_idx_r <= out_idx_r + 3'd1;
      end
    end
  end

  // operand stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) begin
        base_r[k] <= '0;
        exp_r[k]  <= '0;
        mod_r[k]  <= '0;
      end
    end else if (in_beat && (32'(in_idx) < NW)) begin
      case (in_tuser)
        mexp_pkg::ACT_LOAD_BASE: base_r[mexp_pkg::IDX_W'(in_idx)] <= in_word;
        mexp_pkg::ACT_LOAD_EXP:  exp_r[mexp_pkg::IDX_W'(in_idx)]  <= in_word;
        mexp_pkg::ACT_LOAD_MOD:  mod_r[mexp_pkg::IDX_W'(in_idx)]  <= in_word;
        default: begin
          base_r[0] <= base_r[0];
        end
      endcase
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (state_r == mexp_pkg::ST_CHECK) begin
      acc_r <= mod_zero ? '0 : OB'(1);
    end else if ((state_r == mexp_pkg::ST_MUL_DONE) && (kind_r == mexp_pkg::MK_ACC)) begin
      acc_r <= r_flat[OB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == mexp_pkg::ST_CHECK) begin
      e_r <= exp_flat;
    end else if ((state_r == mexp_pkg::ST_MUL_DONE) && (kind_r == mexp_pkg::MK_SQR)) begin
      e_r <= e_r >> 1;
    end
    if ((state_r == mexp_pkg::ST_MUL_DONE) && (kind_r != mexp_pkg::MK_ACC)) begin
      b_r <= r_flat[OB-1:0];
    end
    if (start_mul) begin
      a_r   <= mult_sel;
      cnt_r <= mexp_pkg::CNT_W'(OB);
    end else if (state_r == mexp_pkg::ST_MUL_ADD) begin
      a_r   <= a_r << 1;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // result beat
  assign acc_word  = acc_pad[mexp_pkg::IDX_W'(out_idx_r)*WB +: WB];
  assign out_tdata = {5'b0, out_idx_r, 64'(acc_word)};
  assign out_tuser = err_r;
  assign out_tlast = (out_idx_r == 3'(mexp_pkg::OUT_WORDS - 1));

  // checks
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and result channels open together");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[63:0] == 64'd0))
    else $error("error beat carries nonzero data");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_MUL_ADD) |-> (cnt_r != '0))
    else $error("multiply step with exhausted bit count");

  a_sub_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mexp_pkg::ST_MUL_SUB1) |-> ($past(state_r) == mexp_pkg::ST_MUL_ADD))
    else $error("subtract phase not preceded by add phase");

endmodule

@@ verif/modular_exponentiation_core_test.sv @@
// testbench for the modular exponentiation core: directed and random beats, checked results
`timescale 1ns / 1ps
module modular_exponentiation_core_test;

  typedef struct {
    mexp_pkg::action_t act;
    logic [2:0]  idx;
    logic [63:0] val;
    bit          drain;
  } in_beat_t;

  typedef struct {
    logic [63:0] word;
    logic [2:0]  idx;
    logic        last;
    logic        err;
  } res_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [mexp_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = 2'd0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [mexp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  in_beat_t  beats_pending[$];
  res_beat_t expected_words[$];

  // operand copies kept by the predictor
  logic [mexp_pkg::OPERAND_BITS-1:0] base_op, exp_op, mod_op;

  int unsigned offered_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_left = 0;
  bit hold_done = 0;
  bit run_live = 0;

  modular_exponentiation_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [mexp_pkg::OPERAND_BITS-1:0] mul_mod(
      input logic [mexp_pkg::OPERAND_BITS-1:0] a,
      input logic [mexp_pkg::OPERAND_BITS-1:0] b,
      input logic [mexp_pkg::OPERAND_BITS-1:0] m);
    logic [2*mexp_pkg::OPERAND_BITS-1:0] p;
    p = {{mexp_pkg::OPERAND_BITS{1'b0}}, a} * {{mexp_pkg::OPERAND_BITS{1'b0}}, b};
    p = p % {{mexp_pkg::OPERAND_BITS{1'b0}}, m};
    return p[mexp_pkg::OPERAND_BITS-1:0];
  endfunction

  // apply one accepted beat to the operand copies, queue the result words of a start
  task automatic predict_modexp(input mexp_pkg::action_t act, input logic [2:0] idx,
                                input logic [63:0] val);
    logic [mexp_pkg::OPERAND_BITS-1:0] acc, sq;
    logic err;
    res_beat_t r;
    int top;
    acc = '0;
    err = 1'b0;
    top = -1;
    case (act)
      mexp_pkg::ACT_LOAD_BASE: base_op[idx*64 +: 64] = val;
      mexp_pkg::ACT_LOAD_EXP:  exp_op[idx*64 +: 64] = val;
      mexp_pkg::ACT_LOAD_MOD:  mod_op[idx*64 +: 64] = val;
      default: begin
        if (mod_op == '0) begin
          err = 1'b1;
        end else begin
          acc = mexp_pkg::OPERAND_BITS'(1);
          for (int i = 0; i < mexp_pkg::OPERAND_BITS; i++) if (exp_op[i]) top = i;
          // zero exponent leaves 1 unreduced
          if (top >= 0) begin
            sq = base_op % mod_op;
            for (int i = 0; i <= top; i++) begin
              if (exp_op[i]) acc = mul_mod(acc, sq, mod_op);
              if (i < top) sq = mul_mod(sq, sq, mod_op);
            end
          end
        end
        for (int k = 0; k < mexp_pkg::OUT_WORDS; k++) begin
          r.word = acc[k*64 +: 64];
          r.idx = k[2:0];
          r.last = (k == mexp_pkg::OUT_WORDS - 1);
          r.err = err;
          expected_words.push_back(r);
        end
      end
    endcase
  endtask

  task automatic add_beat(input mexp_pkg::action_t act, input logic [2:0] idx,
                          input logic [63:0] val, input bit drain = 0);
    in_beat_t b;
    b.act = act;
    b.idx = idx;
    b.val = val;
    b.drain = drain;
    beats_pending.push_back(b);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // idle percentages per phase, switched by accepted beat count
  function automatic int sender_idle();
    if (accepted_cnt < 45) return 14;
    if (accepted_cnt < 90) return 83;
    return 0;
  endfunction

  function automatic int receiver_idle();
    if (accepted_cnt < 45) return 83;
    if (accepted_cnt < 90) return 14;
    return 0;
  endfunction

  // input beat acceptance and prediction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_modexp(mexp_pkg::action_t'(in_tuser), in_tdata[2:0], in_tdata[66:3]);
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  // driver: next beat from the pending queue at the falling edge
  always @(negedge clk) begin
    in_beat_t b;
    if (run_live && !(in_tvalid && accepted_cnt != offered_cnt)) begin
      if (beats_pending.size() > 0 && !(beats_pending[0].drain && expected_words.size() > 0)
          && $urandom_range(99) >= sender_idle()) begin
        b = beats_pending.pop_front();
        in_tdata <= {5'd0, b.val, b.idx};
        in_tuser <= b.act;
        in_tvalid <= 1'b1;
        offered_cnt <= offered_cnt + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off while a start is in flight
  always @(negedge clk) begin
    if (!run_live) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 30 && expected_words.size() > 0) begin
      hold_done <= 1;
      hold_left <= 60000;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_idle());
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    res_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("unexpected result beat: word %h idx %0d last %b err %b",
                   out_tdata[63:0], out_tdata[66:64], out_tlast, out_tuser);
      end else begin
        e = expected_words.pop_front();
        if (out_tdata[63:0] !== e.word || out_tdata[66:64] !== e.idx ||
            out_tlast !== e.last || out_tuser !== e.err) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("result mismatch: expected word %h idx %0d last %b err %b, %s %h %0d %b %b",
                     e.word, e.idx, e.last, e.err, "got",
                     out_tdata[63:0], out_tdata[66:64], out_tlast, out_tuser);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 4000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] v;
    int n;
    base_op = '0;
    exp_op = '0;
    mod_op = '0;

    // directed: zero modulus, zero exponent, modulus one, wide values
    add_beat(mexp_pkg::ACT_START, 3'd5, rand64());
    add_beat(mexp_pkg::ACT_LOAD_MOD, 3'd0, 64'd1, 1);
    add_beat(mexp_pkg::ACT_START, 3'd0, 64'd0);
    add_beat(mexp_pkg::ACT_LOAD_EXP, 3'd0, 64'd5, 1);
    add_beat(mexp_pkg::ACT_START, 3'd7, '1);
    add_beat(mexp_pkg::ACT_LOAD_BASE, 3'd0, '1, 1);
    add_beat(mexp_pkg::ACT_LOAD_BASE, 3'd7, '1);
    add_beat(mexp_pkg::ACT_LOAD_MOD, 3'd7, '1);
    add_beat(mexp_pkg::ACT_LOAD_MOD, 3'd0, '1);
    add_beat(mexp_pkg::ACT_LOAD_EXP, 3'd7, '1);
    add_beat(mexp_pkg::ACT_LOAD_EXP, 3'd7, 64'd0);
    add_beat(mexp_pkg::ACT_LOAD_EXP, 3'd0, 64'hfff);
    add_beat(mexp_pkg::ACT_START, 3'd0, 64'd0);
    // base below a small modulus, then zero modulus with nonzero exponent
    add_beat(mexp_pkg::ACT_LOAD_MOD, 3'd7, 64'd0, 1);
    add_beat(mexp_pkg::ACT_LOAD_MOD, 3'd0, 64'd1000003);
    add_beat(mexp_pkg::ACT_LOAD_BASE, 3'd7, 64'd0);
    add_beat(mexp_pkg::ACT_LOAD_BASE, 3'd0, 64'd2);
    add_beat(mexp_pkg::ACT_LOAD_EXP, 3'd0, 64'd10);
    add_beat(mexp_pkg::ACT_START, 3'd0, 64'd0);
    add_beat(mexp_pkg::ACT_LOAD_MOD, 3'd0, 64'd0, 1);
    add_beat(mexp_pkg::ACT_START, 3'd0, 64'd0);

    // random square-and-multiply runs with small exponents
    for (int s = 0; s < 5; s++) begin
      for (int i = 0; i < 8; i++)
        if ($urandom_range(2) != 0) add_beat(mexp_pkg::ACT_LOAD_BASE, i[2:0], rand64());
      n = $urandom_range(1, 8);
      if ($urandom_range(7) == 0) n = 0;
      for (int i = 0; i < 8; i++) begin
        v = (i < n) ? rand64() : 64'd0;
        if (i == n - 1 && v == 0) v = 64'd3;
        add_beat(mexp_pkg::ACT_LOAD_MOD, i[2:0], v);
      end
      // junk into a high exponent word, cleared again
      n = $urandom_range(1, 7);
      add_beat(mexp_pkg::ACT_LOAD_EXP, n[2:0], rand64());
      add_beat(mexp_pkg::ACT_LOAD_EXP, n[2:0], 64'd0);
      n = $urandom_range(1, 12);
      v = (rand64() & ((64'd1 << n) - 1)) | (64'd1 << (n - 1));
      if ($urandom_range(5) == 0) v = 64'd0;
      add_beat(mexp_pkg::ACT_LOAD_EXP, 3'd0, v);
      add_beat(mexp_pkg::ACT_START, 3'($urandom_range(7)), rand64());
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_live = 1;

    while (beats_pending.size() > 0 || accepted_cnt != offered_cnt || expected_words.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/mexp_pkg.sv
hdl/mexp_cell.sv
hdl/modular_exponentiation_core.sv
verif/modular_exponentiation_core_test.sv
